>>> rtl/core/touch_gesture_kinetic_scroller_defines.svh
// Assertion macros used by the scroller top level.
`ifndef TOUCH_GESTURE_KINETIC_SCROLLER_DEFINES_SVH
`define TOUCH_GESTURE_KINETIC_SCROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TGKS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TGKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tgks_pkg.sv
// Types, codes and helper functions of the touch gesture kinetic scroller.
package tgks_pkg;

  localparam int unsigned LONG_TAP_MS    = 150;
  localparam int unsigned TAP_CONFIRM_MS = 100;
  localparam int unsigned STEP_LIMIT     = 24;
  localparam int unsigned SUM_W          = 18;

  localparam logic signed [15:0] VLIMIT_DEFAULT = 16'sd7680;
  localparam logic signed [15:0] STEP_MAX       = 16'(STEP_LIMIT);
  localparam logic signed [15:0] STEP_MIN       = -STEP_MAX;

  // Gesture codes
  localparam logic [2:0] G_NONE   = 3'd0;
  localparam logic [2:0] G_SINGLE = 3'd1;
  localparam logic [2:0] G_DOUBLE = 3'd2;
  localparam logic [2:0] G_LONG   = 3'd3;
  localparam logic [2:0] G_UP     = 3'd4;
  localparam logic [2:0] G_DOWN   = 3'd5;
  localparam logic [2:0] G_LEFT   = 3'd6;
  localparam logic [2:0] G_RIGHT  = 3'd7;

  // Coast modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_HORIZ = 2'd1;
  localparam logic [1:0] MODE_VERT  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_MIN_X   = 3'd0;
  localparam logic [2:0] REG_MIN_Y   = 3'd1;
  localparam logic [2:0] REG_MAX_X   = 3'd2;
  localparam logic [2:0] REG_MAX_Y   = 3'd3;
  localparam logic [2:0] REG_DRAG_H  = 3'd4;
  localparam logic [2:0] REG_DRAG_V  = 3'd5;
  localparam logic [2:0] REG_VLIMIT  = 3'd6;

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic               drag_h;
    logic               drag_v;
    logic signed [15:0] vlimit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [2:0]         touches;
    logic [31:0]        now;
  } poll_t;

  typedef struct packed {
    logic [2:0]         gesture;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic [1:0]         mode;
    logic               pen_down;
  } result_t;

  typedef struct packed {
    logic               pen_down;
    logic [31:0]        down_stamp;
    logic [31:0]        up_stamp;
    logic [31:0]        gap;
    logic [7:0]         tap_count;
    logic               ignore;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic               last_valid;
    logic [2:0]         sticky;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic [1:0]         mode;
  } state_t;

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = 17'(v);
    return (v < 0) ? 17'(-w) : 17'(w);
  endfunction

  // min against hi first, then lo wins; inverted bounds give lo
  function automatic logic signed [15:0] clamp16(input logic signed [SUM_W-1:0] v,
                                                 input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] lo_w;
    logic signed [SUM_W-1:0] hi_w;
    lo_w = SUM_W'(lo);
    hi_w = SUM_W'(hi);
    t = (v < hi_w) ? v : hi_w;
    return (t > lo_w) ? t[15:0] : lo;
  endfunction

endpackage

>>> rtl/core/tgks_coast.sv
// One decay-and-move step of the coasting scroll base on one axis.
module tgks_coast
  import tgks_pkg::*;
(
  input  logic signed [15:0] vel,
  input  logic signed [15:0] base,
  input  logic signed [15:0] lo,
  input  logic signed [15:0] hi,
  output logic signed [15:0] vel_next,
  output logic signed [15:0] base_next,
  output logic               active
);

  logic [16:0]        mag;
  logic signed [16:0] chg;
  logic signed [16:0] vel_w;
  logic signed [16:0] vel_dec;
  logic signed [15:0] step;

  always_comb begin
    mag = abs17(vel);
    chg = $signed(mag >> 6);
    if (chg == '0) begin
      chg = 17'sd1;
    end
    vel_w = 17'(vel);
    vel_dec = (vel < 0) ? (vel_w + chg) : (vel_w - chg);
    vel_next = vel_dec[15:0];

    if (vel_next > STEP_MAX) begin
      step = STEP_MAX;
    end else if (vel_next < STEP_MIN) begin
      step = STEP_MIN;
    end else begin
      step = vel_next;
    end

    base_next = clamp16(SUM_W'(base) + SUM_W'(step), lo, hi);
    active = !((vel_next == '0) || (base_next <= lo) || (base_next >= hi));
  end

endmodule

>>> rtl/core/tgks_step.sv
// Next-state and result logic for one touch poll.
module tgks_step
  import tgks_pkg::*;
(
  input  state_t  cur,
  input  poll_t   poll,
  input  cfg_t    cfg,
  output state_t  nxt,
  output result_t res
);

  logic               penup;
  logic [2:0]         gest;
  logic [31:0]        held_ms;
  logic [31:0]        up_ms;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic [16:0]        ax;
  logic [16:0]        ay;
  logic signed [15:0] vlim;
  logic               sel_v;
  logic signed [15:0] c_vel;
  logic signed [15:0] c_base;
  logic signed [15:0] c_lo;
  logic signed [15:0] c_hi;
  logic signed [15:0] c_vel_next;
  logic signed [15:0] c_base_next;
  logic               c_active;

  // only one axis coasts at a time
  assign sel_v  = (cur.mode == MODE_VERT);
  assign c_vel  = sel_v ? cur.vel_y  : cur.vel_x;
  assign c_base = sel_v ? cur.base_y : cur.base_x;
  assign c_lo   = sel_v ? cfg.min_y  : cfg.min_x;
  assign c_hi   = sel_v ? cfg.max_y  : cfg.max_x;

  tgks_coast u_coast (
    .vel       (c_vel),
    .base      (c_base),
    .lo        (c_lo),
    .hi        (c_hi),
    .vel_next  (c_vel_next),
    .base_next (c_base_next),
    .active    (c_active)
  );

  always_comb begin
    nxt = cur;
    gest = G_NONE;
    penup = (poll.touches == '0);

    // pen tracking
    if (!penup && !cur.pen_down) begin
      nxt.pen_down   = 1'b1;
      nxt.down_stamp = poll.now;
      nxt.gap        = cur.up_stamp;
      nxt.up_stamp   = '0;
    end else if (penup && cur.pen_down) begin
      nxt.pen_down = 1'b0;
      nxt.up_stamp = poll.now;
    end

    // tap timing, wrap-safe differences
    held_ms = poll.now - nxt.down_stamp;
    up_ms   = poll.now - nxt.up_stamp;
    if (nxt.pen_down) begin
      if (held_ms > 32'(LONG_TAP_MS)) begin
        gest = G_LONG;
        nxt.ignore = 1'b1;
      end else if (nxt.gap != '0) begin
        nxt.gap = '0;
        nxt.tap_count = cur.tap_count + 8'd1;
      end
    end else if (up_ms > 32'(TAP_CONFIRM_MS)) begin
      if (cur.tap_count == 8'd1) begin
        gest = G_SINGLE;
      end else if (cur.tap_count == 8'd2) begin
        gest = G_DOUBLE;
      end
      nxt.tap_count = '0;
    end

    // drag and coast
    dx = cur.last_x - poll.px;
    dy = cur.last_y - poll.py;
    ax = abs17(dx);
    ay = abs17(dy);
    if (!penup) begin
      if (cur.last_valid) begin
        if (ay > ax) begin
          nxt.sticky = (dy > 0) ? G_UP : G_DOWN;
          nxt.vel_y  = dy;
          nxt.mode   = MODE_VERT;
          if (cfg.drag_v) begin
            nxt.base_y = clamp16(SUM_W'(cur.base_y) + SUM_W'(dy), cfg.min_y, cfg.max_y);
            gest = nxt.sticky;
          end
        end else if (ay < ax) begin
          nxt.sticky = (dx > 0) ? G_LEFT : G_RIGHT;
          nxt.vel_x  = dx;
          nxt.mode   = MODE_HORIZ;
          if (cfg.drag_h) begin
            nxt.base_x = clamp16(SUM_W'(cur.base_x) + SUM_W'(dx), cfg.min_x, cfg.max_x);
            gest = nxt.sticky;
          end
        end
      end
      nxt.last_x = poll.px;
      nxt.last_y = poll.py;
      nxt.last_valid = 1'b1;
    end else begin
      nxt.last_valid = 1'b0;
      if (cur.mode == MODE_HORIZ || cur.mode == MODE_VERT) begin
        gest = cur.sticky;
        if (sel_v) begin
          nxt.vel_y  = c_vel_next;
          nxt.base_y = c_base_next;
        end else begin
          nxt.vel_x  = c_vel_next;
          nxt.base_x = c_base_next;
        end
        if (c_active) begin
          nxt.tap_count = '0;
        end else begin
          nxt.mode = MODE_IDLE;
        end
      end
    end

    // first gesture after a long tap is swallowed on release
    if (penup && nxt.ignore && gest != G_NONE) begin
      nxt.ignore = 1'b0;
      gest = G_NONE;
    end

    vlim = (cfg.vlimit == '0) ? VLIMIT_DEFAULT : cfg.vlimit;
    if (nxt.base_y >= vlim) begin
      nxt.base_y = vlim;
    end

    res.gesture  = gest;
    res.base_x   = nxt.base_x;
    res.base_y   = nxt.base_y;
    res.mode     = nxt.mode;
    res.pen_down = nxt.pen_down;
  end

endmodule

>>> rtl/core/touch_gesture_kinetic_scroller.sv
// Top level of the touch gesture kinetic scroller: registers, handshake and state.
// A word accepted into the input register passes through the result register to the output.
// Throughput: one poll per cycle while the output is not stalled; the step logic between
// the input register and the result register is combinational.
// Reset (rst, synchronous): clears scroll state and both valid flags; vertical limit 7680.
module touch_gesture_kinetic_scroller
  import tgks_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [2:0]         touches_present,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         gesture,
  output logic signed [15:0] scroll_base_x,
  output logic signed [15:0] scroll_base_y,
  output logic [1:0]         scroll_mode,
  output logic               pen_is_down,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

`include "touch_gesture_kinetic_scroller_defines.svh"

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  poll_t   s1_poll;
  logic    s1_valid;
  result_t step_res;
  result_t o_res;
  logic    o_valid;
  logic    o_ready;
  logic    s1_ready;
  logic    s1_fire;

  assign o_ready  = !o_valid || !out_stall;
  assign s1_ready = !s1_valid || o_ready;
  assign s1_fire  = s1_valid && o_ready;
  assign in_stall = !s1_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_x  <= '0;
      cfg.min_y  <= '0;
      cfg.max_x  <= '0;
      cfg.max_y  <= '0;
      cfg.drag_h <= 1'b0;
      cfg.drag_v <= 1'b0;
      cfg.vlimit <= VLIMIT_DEFAULT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_X:  cfg.min_x  <= cfg_data;
        REG_MIN_Y:  cfg.min_y  <= cfg_data;
        REG_MAX_X:  cfg.max_x  <= cfg_data;
        REG_MAX_Y:  cfg.max_y  <= cfg_data;
        REG_DRAG_H: cfg.drag_h <= cfg_data[0];
        REG_DRAG_V: cfg.drag_v <= cfg_data[0];
        REG_VLIMIT: cfg.vlimit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_poll.px      <= point_x;
      s1_poll.py      <= point_y;
      s1_poll.touches <= touches_present;
      s1_poll.now     <= now_ms;
    end
  end

  tgks_step u_step (
    .cur  (state),
    .poll (s1_poll),
    .cfg  (cfg),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_res <= step_res;
    end
  end

  assign out_valid     = o_valid;
  assign gesture       = o_res.gesture;
  assign scroll_base_x = o_res.base_x;
  assign scroll_base_y = o_res.base_y;
  assign scroll_mode   = o_res.mode;
  assign pen_is_down   = o_res.pen_down;

  `TGKS_ASSERT_NEXT(a_pen_tracks_touch, s1_fire, state.pen_down == $past(s1_poll.touches != '0), "pen flag does not follow touch count")
  `TGKS_ASSERT_NEXT(a_long_sets_ignore, s1_fire && step_res.gesture == G_LONG, state.ignore, "long tap did not arm ignore")
  `TGKS_ASSERT_NEXT(a_step_delivers, s1_fire, out_valid, "processed word not presented")
  `TGKS_ASSERT_NOW(a_stall_needs_busy, in_stall, s1_valid && o_valid, "input stalled with free stage")

endmodule

>>> test/tb_touch_gesture_kinetic_scroller.sv
// Self-checking testbench for the touch gesture kinetic scroller: tap, long tap, drag and coasting.
module tb_touch_gesture_kinetic_scroller
  import tgks_pkg::*;
;

  localparam int MAX_TOUCHES = 5;
  localparam int STEP_CAP    = STEP_LIMIT;
  localparam int DRAIN_SLACK = 6;
  localparam int HOLD_OFF    = 300;
  localparam int PHASE_ITEMS = 100;
  localparam logic signed [15:0] NO_POINT = 16'sh8000;

  // Tracks gesture and scroll state per accepted poll and checks each output word.
  class gesture_board;
    cfg_t               cfg;
    bit                 pen_down;
    bit [31:0]          down_stamp;
    bit [31:0]          up_stamp;
    bit [31:0]          gap;
    bit [7:0]           taps;
    bit                 hold_after_long;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    bit                 last_valid;
    bit [2:0]           sticky;
    int                 vel_x;
    int                 vel_y;
    int                 base_x;
    int                 base_y;
    bit [1:0]           mode;
    result_t            pending_results[$];
    int                 mismatches;

    function new();
      cfg = '0;
      cfg.vlimit = VLIMIT_DEFAULT;
      pen_down = 0; down_stamp = 0; up_stamp = 0; gap = 0;
      taps = 0; hold_after_long = 0;
      last_x = 0; last_y = 0; last_valid = 0;
      sticky = G_NONE; mode = MODE_IDLE;
      vel_x = 0; vel_y = 0; base_x = 0; base_y = 0;
      mismatches = 0;
    endfunction

    function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    // upper bound first, so inverted bounds land on lo
    function int clamp_int(int v, int lo, int hi);
      int t;
      t = (v < hi) ? v : hi;
      return (t > lo) ? t : lo;
    endfunction

    function bit coast_step(inout int vel, inout int base, input int lo, input int hi);
      int change;
      change = mag(vel) >> 6;
      if (change < 1) change = 1;
      if (vel < 0) vel += change;
      else vel -= change;
      if (vel > 0) base += (vel < STEP_CAP) ? vel : STEP_CAP;
      if (vel < 0) base += (vel > -STEP_CAP) ? vel : -STEP_CAP;
      base = clamp_int(base, lo, hi);
      return !(vel == 0 || base <= lo || base >= hi);
    endfunction

    function void note_poll(poll_t p);
      int                 cnt;
      bit                 lifted;
      bit [2:0]           g;
      bit [31:0]          elapsed;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      int                 ax;
      int                 ay;
      int                 lim;
      result_t            r;
      cnt = (p.touches > MAX_TOUCHES) ? MAX_TOUCHES : p.touches;
      lifted = (cnt == 0);
      g = G_NONE;

      if (!lifted && !pen_down) begin
        pen_down = 1;
        down_stamp = p.now;
        gap = up_stamp;
        up_stamp = 0;
      end else if (lifted && pen_down) begin
        pen_down = 0;
        up_stamp = p.now;
      end

      if (pen_down) begin
        elapsed = p.now - down_stamp;
        if (elapsed > LONG_TAP_MS) begin
          g = G_LONG;
          hold_after_long = 1;
        end else if (gap != 0) begin
          gap = 0;
          taps = taps + 8'd1;
        end
      end else begin
        elapsed = p.now - up_stamp;
        if (lifted && elapsed > TAP_CONFIRM_MS) begin
          if (taps == 8'd1) g = G_SINGLE;
          else if (taps == 8'd2) g = G_DOUBLE;
          taps = 0;
        end
      end

      if (!lifted) begin
        if (last_valid) begin
          dx = last_x - p.px;
          dy = last_y - p.py;
          ax = mag(int'(dx));
          ay = mag(int'(dy));
          if (ay > ax) begin
            sticky = (dy > 0) ? G_UP : G_DOWN;
            vel_y = dy;
            mode = MODE_VERT;
            if (cfg.drag_v) begin
              base_y = clamp_int(base_y + dy, cfg.min_y, cfg.max_y);
              g = sticky;
            end
          end else if (ay < ax) begin
            sticky = (dx > 0) ? G_LEFT : G_RIGHT;
            vel_x = dx;
            mode = MODE_HORIZ;
            if (cfg.drag_h) begin
              base_x = clamp_int(base_x + dx, cfg.min_x, cfg.max_x);
              g = sticky;
            end
          end
        end
        last_x = p.px;
        last_y = p.py;
        last_valid = 1;
      end else begin
        last_valid = 0;
        if (mode == MODE_HORIZ) begin
          g = sticky;
          if (coast_step(vel_x, base_x, cfg.min_x, cfg.max_x)) taps = 0;
          else mode = MODE_IDLE;
        end else if (mode == MODE_VERT) begin
          g = sticky;
          if (coast_step(vel_y, base_y, cfg.min_y, cfg.max_y)) taps = 0;
          else mode = MODE_IDLE;
        end
      end

      // first gesture after a long tap is swallowed on pen up
      if (lifted && hold_after_long && g != G_NONE) begin
        hold_after_long = 0;
        g = G_NONE;
      end

      lim = (cfg.vlimit == 0) ? VLIMIT_DEFAULT : cfg.vlimit;
      if (base_y >= lim) base_y = lim;

      r.gesture = g;
      r.base_x = base_x[15:0];
      r.base_y = base_y[15:0];
      r.mode = mode;
      r.pen_down = pen_down;
      pending_results.push_back(r);
    endfunction

    function void field_error(string name, logic signed [15:0] want,
                              logic signed [15:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: output word with no poll pending, gesture %0d base %0d,%0d",
                 $time, got.gesture, got.base_x, got.base_y);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.gesture !== want.gesture) field_error("gesture", want.gesture, got.gesture);
      if (got.base_x !== want.base_x) field_error("scroll_base_x", want.base_x, got.base_x);
      if (got.base_y !== want.base_y) field_error("scroll_base_y", want.base_y, got.base_y);
      if (got.mode !== want.mode) field_error("scroll_mode", want.mode, got.mode);
      if (got.pen_down !== want.pen_down)
        field_error("pen_is_down", want.pen_down, got.pen_down);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic [2:0]         touches_present;
  logic [31:0]        now_ms;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         gesture;
  logic signed [15:0] scroll_base_x;
  logic signed [15:0] scroll_base_y;
  logic [1:0]         scroll_mode;
  logic               pen_is_down;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  gesture_board board = new();
  bit          quiet;
  int          hold_cycles;
  int          items_sent;
  logic [31:0] clock_ms;

  touch_gesture_kinetic_scroller dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .point_x         (point_x),
    .point_y         (point_y),
    .touches_present (touches_present),
    .now_ms          (now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .gesture         (gesture),
    .scroll_base_x   (scroll_base_x),
    .scroll_base_y   (scroll_base_y),
    .scroll_mode     (scroll_mode),
    .pen_is_down     (pen_is_down),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one poll word, idling at random first; returns at the accepting edge.
  task automatic send_poll(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic [2:0] touches, input logic [31:0] ms);
    poll_t p;
    bit    taken;
    p.px = x;
    p.py = y;
    p.touches = touches;
    p.now = ms;
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    touches_present <= touches;
    now_ms <= ms;
    do begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    board.note_poll(p);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Write all seven registers on back-to-back cycles; block must be idle.
  task automatic apply_settings(input cfg_t c);
    logic [2:0]  idx[7];
    logic [15:0] val[7];
    idx = '{REG_MIN_X, REG_MIN_Y, REG_MAX_X, REG_MAX_Y, REG_DRAG_H, REG_DRAG_V, REG_VLIMIT};
    // flag registers only look at bit 0; upper bits get junk
    val = '{c.min_x, c.min_y, c.max_x, c.max_y, {15'($urandom), c.drag_h},
            {15'($urandom), c.drag_v}, c.vlimit};
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    board.cfg = c;
  endtask

  // Output side: random stall, plus a long hold-off on request.
  initial begin : result_sink
    result_t got;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= (!quiet && $urandom_range(99) < 38);
      end
      @(negedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.gesture = gesture;
        got.base_x = scroll_base_x;
        got.base_y = scroll_base_y;
        got.mode = scroll_mode;
        got.pen_down = pen_is_down;
        board.check_result(got);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    cfg_t               dir_cfg;
    cfg_t               c;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    int                 target;
    int                 pick;
    int                 step;
    bit                 paused;
    bit                 vert;

    rst = 1'b1;
    in_valid = 1'b0;
    point_x = '0;
    point_y = '0;
    touches_present = '0;
    now_ms = '0;
    cfg_write = 1'b0;
    cfg_index = REG_MIN_X;
    cfg_data = '0;
    quiet = 0;
    hold_cycles = 0;
    items_sent = 0;
    paused = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // vertical limit 0 selects the default cap
    dir_cfg = '{-16'sd200, -16'sd200, 16'sd200, 16'sd200, 1'b1, 1'b1, 16'sd0};
    apply_settings(dir_cfg);

    // first press after reset is not a tap; point at the origin is real
    send_poll(16'sd0, 16'sd0, 3'd1, 32'd1000);
    send_poll(16'sd0, 16'sd0, 3'd1, 32'd1020);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd1040);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd1200);
    // single tap, then double tap
    send_poll(16'sd10, 16'sd10, 3'd2, 32'd1250);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd1290);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd1400);
    send_poll(16'sd10, 16'sd10, 3'd5, 32'd1450);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd1480);
    send_poll(16'sd10, 16'sd10, 3'd4, 32'd1500);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd1530);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd1650);
    // long tap with counts above the point limit; the tap after it is swallowed
    send_poll(16'sd20, 16'sd20, 3'd7, 32'd2000);
    send_poll(16'sd20, 16'sd20, 3'd6, 32'd2200);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd2220);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd2400);
    // vertical then horizontal drag, coast after release
    send_poll(16'sd0, 16'sd0, 3'd1, 32'd2500);
    send_poll(16'sd5, -16'sd60, 3'd1, 32'd2510);
    send_poll(-16'sd100, -16'sd62, 3'd3, 32'd2520);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd2530);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd2540);
    // fresh press at one point, then full-range wrap of the difference
    send_poll(16'sd30, 16'sd30, 3'd1, 32'd2600);
    send_poll(16'sd32767, 16'sh8000, 3'd1, 32'd2610);
    send_poll(16'sh8000, 16'sd0, 3'd1, 32'd2620);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'd2630);
    // hold timer across the 32-bit wrap, pen up at time zero
    send_poll(16'sd1, 16'sd1, 3'd1, 32'hFFFF_FFC0);
    send_poll(16'sd1, 16'sd1, 3'd1, 32'h0000_0050);
    send_poll(16'sd1, 16'sd1, 3'd1, 32'h0000_0060);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'h0000_0000);
    send_poll(16'sd1, 16'sd1, 3'd1, 32'h0000_00C8);
    send_poll(NO_POINT, NO_POINT, 3'd0, 32'h0000_0190);
    clock_ms = 32'd5000;

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: c = dir_cfg;
        1: c = '{16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 16'sd32767};
        2: c = '{16'sd100, 16'sh8000, -16'sd100, 16'sd32767, 1'b1, 1'b0, 16'sh8000};
        3: c = '{-16'sd500, -16'sd500, 16'sd500, 16'sd500, 1'b0, 1'b1, 16'sd50};
        default: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
          if ($urandom_range(4) != 0 && lo > hi) {lo, hi} = {hi, lo};
          c.min_x = lo;
          c.max_x = hi;
          lo = 16'($urandom);
          hi = 16'($urandom);
          if ($urandom_range(4) != 0 && lo > hi) {lo, hi} = {hi, lo};
          c.min_y = lo;
          c.max_y = hi;
          c.drag_h = 1'($urandom);
          c.drag_v = 1'($urandom);
          c.vlimit = ($urandom_range(3) == 0) ? 16'sd0 : 16'($urandom);
        end
      endcase
      apply_settings(c);
      quiet = (phase == 1);
      if (phase == 2) hold_cycles = HOLD_OFF;
      target = items_sent + PHASE_ITEMS;

      while (items_sent < target) begin
        if (phase == 3 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1;
        end
        if ($urandom_range(29) == 0) clock_ms = 32'hFFFF_FF00 + $urandom_range(255);
        pick = $urandom_range(19);
        if (pick < 5) begin
          // one to three short taps, then confirm polls
          x = 16'($urandom_range(800));
          y = 16'($urandom_range(800));
          repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(1, 3)) begin
              send_poll(x, y, 3'($urandom_range(1, 7)), clock_ms);
              clock_ms += $urandom_range(5, 40);
            end
            send_poll(NO_POINT, NO_POINT, 3'd0, clock_ms);
            clock_ms += $urandom_range(10, 70);
          end
          repeat ($urandom_range(1, 4)) begin
            send_poll(NO_POINT, NO_POINT, 3'd0, clock_ms);
            clock_ms += $urandom_range(20, 80);
          end
        end else if (pick < 8) begin
          // long press held in place
          x = 16'($urandom);
          y = 16'($urandom);
          repeat ($urandom_range(2, 5)) begin
            send_poll(x, y, 3'($urandom_range(1, 7)), clock_ms);
            clock_ms += $urandom_range(40, 90);
          end
          repeat ($urandom_range(2, 4)) begin
            send_poll(NO_POINT, NO_POINT, 3'd0, clock_ms);
            clock_ms += $urandom_range(30, 80);
          end
        end else if (pick < 16) begin
          // drag along one axis, occasional jump, then coast
          x = 16'($urandom);
          y = 16'($urandom);
          vert = 1'($urandom);
          repeat ($urandom_range(2, 6)) begin
            send_poll(x, y, 3'($urandom_range(1, 7)), clock_ms);
            clock_ms += $urandom_range(5, 20);
            step = $urandom_range(160) - 80;
            if ($urandom_range(9) == 0) begin
              x = x + 16'($urandom);
              y = y + 16'($urandom);
            end else if (vert) begin
              y = y + 16'(step);
              x = x + 16'($urandom_range(2)) - 16'sd1;
            end else begin
              x = x + 16'(step);
              y = y + 16'($urandom_range(2)) - 16'sd1;
            end
          end
          repeat ($urandom_range(1, 40)) begin
            send_poll(NO_POINT, NO_POINT, 3'd0, clock_ms);
            clock_ms += $urandom_range(5, 30);
          end
        end else begin
          // noise: any field value, any time
          repeat ($urandom_range(1, 4)) begin
            send_poll(16'($urandom), 16'($urandom), 3'($urandom_range(7)),
                      ($urandom_range(2) == 0) ? $urandom : clock_ms);
            clock_ms += $urandom_range(200);
          end
        end
      end
      quiet = 0;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
